[rtl/ics_pkg.sv]
// Shared types and constants for the instruction control sequencer.
`default_nettype none

package ics_pkg;

  // Phase codes.
  localparam logic [3:0] PH_INIT  = 4'd0;
  localparam logic [3:0] PH_TEST  = 4'd1;
  localparam logic [3:0] PH_E0    = 4'd2;
  localparam logic [3:0] PH_E1    = 4'd3;
  localparam logic [3:0] PH_E1BIS = 4'd4;
  localparam logic [3:0] PH_E2    = 4'd5;
  localparam logic [3:0] PH_T0    = 4'd6;
  localparam logic [3:0] PH_T1    = 4'd7;
  localparam logic [3:0] PH_T2    = 4'd8;

  // Strobe bit positions.
  localparam int S_WR     = 0;
  localparam int S_LDIR   = 1;
  localparam int S_PCLD   = 2;
  localparam int S_ERLD   = 3;
  localparam int S_SIPLD  = 4;
  localparam int S_SVOPLD = 5;
  localparam int S_SOPLD  = 6;
  localparam int S_CLRZ   = 7;
  localparam int S_CLRER  = 8;
  localparam int S_CLREOT = 9;
  localparam int S_SETEOT = 10;
  localparam int S_DWRITE = 11;
  localparam int S_DONE   = 12;
  localparam int S_CLRIRQ = 13;

  localparam int STROBE_W = 14;

  // Addressing modes.
  localparam logic [1:0] AM_0 = 2'd0;
  localparam logic [1:0] AM_1 = 2'd1;
  localparam logic [1:0] AM_2 = 2'd2;

  // Opcodes.
  localparam logic [5:0] OP_LDR     = 6'h00;
  localparam logic [5:0] OP_STR     = 6'h02;
  localparam logic [5:0] OP_SUBV    = 6'h03;
  localparam logic [5:0] OP_SUB     = 6'h04;
  localparam logic [5:0] OP_AND     = 6'h08;
  localparam logic [5:0] OP_OR      = 6'h0C;
  localparam logic [5:0] OP_CLFZ    = 6'h10;
  localparam logic [5:0] OP_SZ      = 6'h14;
  localparam logic [5:0] OP_JMP     = 6'h18;
  localparam logic [5:0] OP_PRESENT = 6'h1C;
  localparam logic [5:0] OP_STRPC   = 6'h1D;
  localparam logic [5:0] OP_MAX     = 6'h1E;
  localparam logic [5:0] OP_CER     = 6'h34;
  localparam logic [5:0] OP_LER     = 6'h36;
  localparam logic [5:0] OP_LSIP    = 6'h37;
  localparam logic [5:0] OP_ADD     = 6'h38;
  localparam logic [5:0] OP_SSOP    = 6'h3A;
  localparam logic [5:0] OP_SSVOP   = 6'h3B;
  localparam logic [5:0] OP_CEOT    = 6'h3C;
  localparam logic [5:0] OP_SEOT    = 6'h3E;

  // ALU functions.
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_AND = 2'd2;
  localparam logic [1:0] ALU_OR  = 2'd3;

  // Program counter sources.
  localparam logic [1:0] PC_INC = 2'd0;
  localparam logic [1:0] PC_OPD = 2'd1;
  localparam logic [1:0] PC_RX  = 2'd2;

  // Write-back sources.
  localparam logic [2:0] WB_OPD = 3'd0;
  localparam logic [2:0] WB_RX  = 3'd1;
  localparam logic [2:0] WB_ALU = 3'd2;
  localparam logic [2:0] WB_MAX = 3'd3;
  localparam logic [2:0] WB_SIP = 3'd4;
  localparam logic [2:0] WB_ER  = 3'd5;
  localparam logic [2:0] WB_MEM = 3'd6;

  // Memory data sources.
  localparam logic [1:0] DM_RX  = 2'd0;
  localparam logic [1:0] DM_OPD = 2'd1;
  localparam logic [1:0] DM_PC  = 2'd2;

  // One decoded input item.
  typedef struct packed {
    logic       zero_flag;
    logic       test_hold;
    logic       interrupt_request;
    logic       dma_pending;
    logic [1:0] mode;
    logic [5:0] opcode;
    logic [3:0] rz;
    logic [3:0] rx;
  } ics_item_t;

  // Held select state, low field last.
  typedef struct packed {
    logic [1:0] dm_data_sel;
    logic       dmw_sel;
    logic       dmr_sel;
    logic [3:0] write_register;
    logic [2:0] writeback_select;
    logic       operand_b_select;
    logic       operand_a_select;
    logic [3:0] read_port_z;
    logic [3:0] read_port_x;
    logic [1:0] alu_operation;
    logic [1:0] pc_select;
  } ics_sel_t;

endpackage

`default_nettype wire

[rtl/ics_decode.sv]
// Phase sequencing and control decode for one clock tick of the sequencer.
`default_nettype none

module ics_decode (
  input  wire  ics_pkg::ics_item_t         item,
  input  wire logic [3:0]                  phase,
  input  wire logic [ics_pkg::STROBE_W-1:0] strobes,
  input  wire  ics_pkg::ics_sel_t          sel,
  output logic [3:0]                       phase_next,
  output logic [ics_pkg::STROBE_W-1:0]     strobes_next,
  output ics_pkg::ics_sel_t                sel_next
);
  import ics_pkg::*;

  logic [STROBE_W-1:0] s;
  ics_sel_t            c;
  logic [3:0]          ph;

  // Update the held controls and the phase for the current phase.
  always_comb begin
    s  = strobes;
    c  = sel;
    ph = phase;
    case (phase)
      PH_INIT: begin
        ph = item.test_hold ? PH_TEST : PH_E0;
      end
      PH_E0: begin
        s = s & ((STROBE_W'(1) << S_DONE) | (STROBE_W'(1) << S_CLRIRQ));
        if (item.dma_pending && item.interrupt_request) begin
          ph = PH_E1;
        end else if (!item.dma_pending && !item.interrupt_request) begin
          if (s[S_DONE]) s[S_CLRIRQ] = 1'b0;
          ph = PH_E2;
        end else begin
          if (!item.interrupt_request && s[S_DONE]) s[S_CLRIRQ] = 1'b0;
          ph = PH_T0;
        end
      end
      PH_T0: begin
        s[S_LDIR]   = 1'b1;
        s[S_PCLD]   = 1'b1;
        c.pc_select = PC_INC;
        ph          = PH_T1;
      end
      PH_T1: begin
        if (item.mode == AM_1 || item.mode == AM_2) begin
          s[S_LDIR]   = 1'b1;
          s[S_PCLD]   = 1'b1;
          c.pc_select = PC_INC;
        end else begin
          s[S_LDIR] = 1'b0;
          s[S_PCLD] = 1'b0;
        end
        if (item.opcode == OP_LER) s[S_ERLD] = 1'b1;
        else if (item.opcode == OP_LSIP) s[S_SIPLD] = 1'b1;
        ph = PH_T2;
      end
      PH_T2: begin
        s[S_LDIR] = 1'b0;
        s[S_PCLD] = 1'b0;
        case (item.mode)
          AM_0: begin
            case (item.opcode)
              OP_CLFZ: s[S_CLRZ]   = 1'b1;
              OP_CER:  s[S_CLRER]  = 1'b1;
              OP_CEOT: s[S_CLREOT] = 1'b1;
              OP_SEOT: s[S_SETEOT] = 1'b1;
              OP_PRESENT: begin
                s[S_CLRZ]          = 1'b1;
                c.alu_operation    = ALU_ADD;
                c.read_port_x      = 4'd0;
                c.read_port_z      = item.rz;
                c.operand_a_select = 1'b0;
                c.operand_b_select = 1'b0;
              end
              default: ;
            endcase
          end
          AM_1: begin
            case (item.opcode)
              OP_AND, OP_OR, OP_ADD, OP_SUBV, OP_SUB: begin
                case (item.opcode)
                  OP_AND:  c.alu_operation = ALU_AND;
                  OP_OR:   c.alu_operation = ALU_OR;
                  OP_ADD:  c.alu_operation = ALU_ADD;
                  default: c.alu_operation = ALU_SUB;
                endcase
                c.read_port_x      = item.rx;
                c.operand_a_select = 1'b1;
                c.operand_b_select = 1'b1;
                if (item.opcode != OP_SUB) begin
                  c.writeback_select = WB_ALU;
                  c.write_register   = item.rz;
                  s[S_WR]            = 1'b1;
                end
              end
              OP_LDR: begin
                c.writeback_select = WB_OPD;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_STR: begin
                c.dmw_sel     = 1'b0;
                c.dm_data_sel = DM_OPD;
                s[S_DWRITE]   = 1'b1;
              end
              OP_JMP: begin
                c.pc_select = PC_OPD;
                s[S_PCLD]   = 1'b1;
              end
              OP_PRESENT, OP_SZ: begin
                if (item.opcode == OP_PRESENT) s[S_CLRZ] = 1'b0;
                if (item.zero_flag) begin
                  c.pc_select = PC_OPD;
                  s[S_PCLD]   = 1'b1;
                end
              end
              OP_MAX: begin
                c.read_port_x      = item.rx;
                c.operand_a_select = 1'b1;
                c.operand_b_select = 1'b1;
                c.writeback_select = WB_MAX;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              default: ;
            endcase
          end
          AM_2: begin
            case (item.opcode)
              OP_LDR: begin
                c.dmr_sel          = 1'b1;
                c.writeback_select = WB_MEM;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_STR: begin
                c.dmw_sel     = 1'b1;
                c.dm_data_sel = DM_RX;
                s[S_DWRITE]   = 1'b1;
              end
              OP_STRPC: begin
                c.dmw_sel     = 1'b1;
                c.dm_data_sel = DM_PC;
                s[S_DWRITE]   = 1'b1;
              end
              default: ;
            endcase
          end
          default: begin
            case (item.opcode)
              OP_AND, OP_OR, OP_ADD: begin
                case (item.opcode)
                  OP_AND:  c.alu_operation = ALU_AND;
                  OP_OR:   c.alu_operation = ALU_OR;
                  default: c.alu_operation = ALU_ADD;
                endcase
                c.read_port_x      = item.rx;
                c.read_port_z      = item.rz;
                c.operand_a_select = 1'b0;
                c.operand_b_select = 1'b0;
                c.writeback_select = WB_ALU;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_LDR: begin
                c.read_port_x      = item.rx;
                c.writeback_select = WB_RX;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_STR: begin
                c.read_port_x = item.rx;
                c.dmw_sel     = 1'b0;
                c.dm_data_sel = DM_RX;
                s[S_DWRITE]   = 1'b1;
              end
              OP_JMP: begin
                c.read_port_x = item.rx;
                c.pc_select   = PC_RX;
                s[S_PCLD]     = 1'b1;
              end
              OP_LER: begin
                c.writeback_select = WB_ER;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_LSIP: begin
                c.writeback_select = WB_SIP;
                c.write_register   = item.rz;
                s[S_WR]            = 1'b1;
              end
              OP_SSVOP: begin
                c.read_port_x = item.rx;
                s[S_SVOPLD]   = 1'b1;
              end
              OP_SSOP: begin
                c.read_port_x = item.rx;
                s[S_SOPLD]    = 1'b1;
              end
              default: ;
            endcase
          end
        endcase
        s[S_DONE] = 1'b1;
        ph = item.test_hold ? PH_TEST : PH_E0;
      end
      default: ;
    endcase
  end

  assign phase_next   = ph;
  assign strobes_next = s;
  assign sel_next     = c;

endmodule

`default_nettype wire

[rtl/instruction_control_sequencer_top.sv]
// Top level of the instruction control sequencer: state, handshake and result register.
`default_nettype none

// Each accepted input transfer is one clock tick of a multicycle processor's
// control unit. The block walks the phases Init, E0, T0, T1, T2 and back to E0
// (Test, E1, E1bis and E2 hold once entered) and returns one result transfer per
// input transfer: the phase during that tick plus the held strobes and selects
// after it. A transfer is decoded in the same cycle it is accepted and its
// result sits in the output register on the next cycle, so one transfer per
// clock is sustained while the output drains; the output register holds a
// stalled result, and s_tready drops only when that register is full and not
// being drained.
module instruction_control_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // instruction[15:0], dma_pending[16], interrupt_request[17], test_hold[18],
  // zero_flag[19], zero fill[23:20]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // phase[3:0], strobes[17:4], pc_select[19:18], alu_operation[21:20],
  // read_port_x[25:22], read_port_z[29:26], operand_a_select[30],
  // operand_b_select[31], writeback_select[34:32], write_register[38:35],
  // memory_selects[42:39], zero fill[47:43]
  output logic [47:0]      m_tdata
);
  import ics_pkg::*;

  logic [3:0]          phase;
  logic [STROBE_W-1:0] strobes;
  ics_sel_t            sel;
  logic [3:0]          phase_next;
  logic [STROBE_W-1:0] strobes_next;
  ics_sel_t            sel_next;
  ics_item_t           item;
  logic                accept;
  logic [3:0]          mem_sel;

  // Unpack the input transfer.
  assign item.rx                = s_tdata[3:0];
  assign item.rz                = s_tdata[7:4];
  assign item.opcode            = s_tdata[13:8];
  assign item.mode              = s_tdata[15:14];
  assign item.dma_pending       = s_tdata[16];
  assign item.interrupt_request = s_tdata[17];
  assign item.test_hold         = s_tdata[18];
  assign item.zero_flag         = s_tdata[19];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  ics_decode u_decode (
    .item         (item),
    .phase        (phase),
    .strobes      (strobes),
    .sel          (sel),
    .phase_next   (phase_next),
    .strobes_next (strobes_next),
    .sel_next     (sel_next)
  );

  // Sequencer state advances once per accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_INIT;
      strobes <= '0;
      sel     <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      strobes <= strobes_next;
      sel     <= sel_next;
    end
  end

  assign mem_sel = {sel_next.dmr_sel, sel_next.dmw_sel, sel_next.dm_data_sel};

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, mem_sel, sel_next.write_register, sel_next.writeback_select,
                  sel_next.operand_b_select, sel_next.operand_a_select,
                  sel_next.read_port_z, sel_next.read_port_x,
                  sel_next.alu_operation, sel_next.pc_select, strobes_next, phase};
    end
  end

endmodule

`default_nettype wire
